### rtl/w30tp_pkg.sv
// Shared types and constants of the wheel-30 twin pair scanner.
package w30tp_pkg;

  localparam int unsigned CntW  = 60;
  localparam int unsigned ValW  = 64;
  localparam int unsigned NHits = 6;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

  // Composite masks over the 16-bit window (this byte, then next byte).
  localparam logic [15:0] MASK_PAIR11 = 16'h000C;
  localparam logic [15:0] MASK_PAIR17 = 16'h0030;
  localparam logic [15:0] MASK_PAIR29 = 16'h0180;
  localparam logic [7:0]  NEXT_ALL_COMPOSITE = 8'hFF;
  localparam logic [7:0]  NEXT_ALL_PRIME     = 8'h00;

  localparam logic [4:0] OFS_PAIR11 = 5'd11;
  localparam logic [4:0] OFS_PAIR17 = 5'd17;
  localparam logic [4:0] OFS_PAIR29 = 5'd29;

  // Configuration register indexes.
  localparam logic [0:0] CFG_FIND_MODE    = 1'b0;
  localparam logic [0:0] CFG_TARGET_INDEX = 1'b1;

  typedef struct packed {
    logic [7:0]      sieve_byte;
    logic [ValW-1:0] block_base;
    logic            segment_last;
    logic            after_end_composite;
    logic            restart;
  } in_item_t;

  typedef struct packed {
    logic [CntW-1:0] pair_count;
    logic            found;
    logic [ValW-1:0] found_value;
  } out_item_t;

  // Pair hits in scan order: held block 11/17/29, then current block 11/17/29.
  typedef struct packed {
    logic [NHits-1:0] hit;
    logic [2:0]       num;
  } pair_hits_t;

  function automatic logic [4:0] pair_offset(input logic [1:0] lane);
    logic [4:0] ofs;
    unique case (lane)
      2'd0:    ofs = OFS_PAIR11;
      2'd1:    ofs = OFS_PAIR17;
      default: ofs = OFS_PAIR29;
    endcase
    return ofs;
  endfunction

endpackage

### rtl/w30tp_pairs.sv
// Twin pair detection over the held block and the current block.
module w30tp_pairs (
  input  logic [7:0]              held_byte_i,
  input  logic                    held_valid_i,
  input  logic [7:0]              cur_byte_i,
  input  logic                    segment_last_i,
  input  logic                    after_end_composite_i,
  output w30tp_pkg::pair_hits_t   hits_o
);
  import w30tp_pkg::*;

  logic [15:0] held_win;
  logic [15:0] cur_win;
  logic [NHits-1:0] hit;

  assign held_win = {cur_byte_i, held_byte_i};
  assign cur_win  = {(after_end_composite_i ? NEXT_ALL_COMPOSITE : NEXT_ALL_PRIME), cur_byte_i};

  assign hit[0] = held_valid_i && ((held_win & MASK_PAIR11) == '0);
  assign hit[1] = held_valid_i && ((held_win & MASK_PAIR17) == '0);
  assign hit[2] = held_valid_i && ((held_win & MASK_PAIR29) == '0);
  assign hit[3] = segment_last_i && ((cur_win & MASK_PAIR11) == '0);
  assign hit[4] = segment_last_i && ((cur_win & MASK_PAIR17) == '0);
  assign hit[5] = segment_last_i && ((cur_win & MASK_PAIR29) == '0);

  assign hits_o.hit = hit;
  assign hits_o.num = 3'($countones(hit));

endmodule

### rtl/wheel30_twin_pair_scanner.sv
// Wheel-30 twin pair scanner: top level.
//
// Input channel: in_valid_i / in_stall_o carry one wheel-30 sieve byte per
// transaction with its block base and segment flags. Output channel:
// out_valid_o / out_stall_i carry one result per input transaction: the
// saturating pair count of the run, the found flag and the located value.
// Configuration: cfg_we_i writes find_mode (index 0) or target_index
// (index 1); a target_index write also reloads the countdown.
// An input register, then the pair detection, count and countdown logic
// feeding the result register. One transaction per cycle is sustained while
// out_stall_i is low; the one-byte hold-back and counters update per advance.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall_o rises only while both are full and out_stall_i is high.
// Reset empties both stages, clears the held byte, count and found state,
// and sets find_mode to 0 and target_index and the countdown to 1.
module wheel30_twin_pair_scanner (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_index_i,
  input  logic [59:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  w30tp_pkg::in_item_t    in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output w30tp_pkg::out_item_t   out_item_o
);
  import w30tp_pkg::*;

  logic            find_mode_q;
  logic [CntW-1:0] target_q;

  logic            s1_valid_q;
  in_item_t        s1_item_q;
  logic            out_valid_q;
  out_item_t       out_item_q;

  logic [7:0]      held_byte_q;
  logic [ValW-1:0] held_base_q;
  logic            held_valid_q, held_valid_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            found_q, found_d;
  logic [ValW-1:0] pos_q, pos_d;

  logic            out_ready;
  logic            advance;
  logic            in_accept;

  logic            eff_held_valid;
  logic [CntW-1:0] eff_count;
  logic [CntW-1:0] eff_rem;
  logic            eff_found;
  logic [ValW-1:0] eff_pos;
  pair_hits_t      hits;
  logic [CntW:0]   sum;
  logic            find_active;
  logic [2:0]      prefix;
  logic            sel_cur;
  logic [1:0]      sel_lane;
  logic [ValW-1:0] sel_base;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Restart takes effect before this byte is scanned.
  assign eff_held_valid = held_valid_q && !s1_item_q.restart;
  assign eff_count = s1_item_q.restart ? '0 : count_q;
  assign eff_rem   = s1_item_q.restart ? target_q : rem_q;
  assign eff_found = s1_item_q.restart ? 1'b0 : found_q;
  assign eff_pos   = s1_item_q.restart ? '0 : pos_q;

  w30tp_pairs u_pairs (
    .held_byte_i           (held_byte_q),
    .held_valid_i          (eff_held_valid),
    .cur_byte_i            (s1_item_q.sieve_byte),
    .segment_last_i        (s1_item_q.segment_last),
    .after_end_composite_i (s1_item_q.after_end_composite),
    .hits_o                (hits)
  );

  assign sum     = {1'b0, eff_count} + (CntW+1)'(hits.num);
  assign count_d = sum[CntW] ? CNT_MAX : sum[CntW-1:0];

  // Locate the hit whose running ordinal equals the (small) countdown.
  always_comb begin
    prefix   = '0;
    sel_cur  = 1'b0;
    sel_lane = '0;
    for (int i = 0; i < NHits; i++) begin
      prefix = prefix + 3'(hits.hit[i]);
      if (hits.hit[i] && (prefix == eff_rem[2:0])) begin
        sel_cur  = (i >= 3);
        sel_lane = 2'(i % 3);
      end
    end
  end

  assign sel_base    = sel_cur ? s1_item_q.block_base : held_base_q;
  assign find_active = find_mode_q && !eff_found && (eff_rem != '0);

  always_comb begin
    rem_d   = eff_rem;
    found_d = eff_found;
    pos_d   = eff_pos;
    if (find_active) begin
      if (eff_rem <= CntW'(hits.num)) begin
        rem_d   = '0;
        found_d = 1'b1;
        pos_d   = sel_base + ValW'(pair_offset(sel_lane));
      end else begin
        rem_d = eff_rem - CntW'(hits.num);
      end
    end
  end

  assign held_valid_d = !s1_item_q.segment_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_mode_q <= 1'b0;
      target_q    <= CntW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FIND_MODE:    find_mode_q <= cfg_data_i[0];
        CFG_TARGET_INDEX: target_q    <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      held_valid_q <= 1'b0;
      count_q      <= '0;
      rem_q        <= CntW'(1);
      found_q      <= 1'b0;
      pos_q        <= '0;
      held_byte_q  <= '0;
      held_base_q  <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
      if (cfg_we_i && (cfg_index_i == CFG_TARGET_INDEX)) begin
        rem_q <= cfg_data_i;
      end else if (advance) begin
        rem_q <= rem_d;
      end
      if (advance) begin
        held_valid_q <= held_valid_d;
        count_q      <= count_d;
        found_q      <= found_d;
        pos_q        <= pos_d;
        if (held_valid_d) begin
          held_byte_q <= s1_item_q.sieve_byte;
          held_base_q <= s1_item_q.block_base;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q.pair_count  <= count_d;
      out_item_q.found       <= found_d;
      out_item_q.found_value <= found_d ? pos_d : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### rtl/w30tp_checker.sv
// Port-level checks of the wheel-30 twin pair scanner, bound to the top level.
module w30tp_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input w30tp_pkg::out_item_t  out_item_o
);
  import w30tp_pkg::*;

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // An empty result register always lets the input stage drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Only a backpressured output can stall the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // No located value is shown before a find.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.found_value == '0)
    else $error("found_value nonzero without found");

endmodule

bind wheel30_twin_pair_scanner w30tp_checker u_w30tp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
